[hdl/ffhp_pkg.sv]
package ffhp_pkg;

	// Width of a stored bound product and of the (1+u) factor
	localparam int unsigned PROD_W = 32;

	typedef struct packed {
		logic        new_set;
		logic [31:0] period;
		logic [31:0] exec_time;
	} ffhp_in_t;

	typedef struct packed {
		logic [3:0] assigned_processor;
		logic [4:0] processors_used;
		logic       within_limit;
		logic [1:0] error_code;
	} ffhp_out_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_UTIL_OVER = 2'd1,
		ERR_NO_PROC   = 2'd2
	} ffhp_err_t;

	// Travels from one processor cell to the next
	typedef struct packed {
		logic claimed;   // an earlier open processor takes the task
		logic open;      // this processor is open
	} ffhp_link_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic clear;     // start a new task set
		logic commit;    // apply the placement decision
	} ffhp_cmd_t;

	// Per-cell decision seen by the controller
	typedef struct packed {
		logic take;      // task placed on this open processor
		logic open_new;  // this processor is opened for the task
	} ffhp_cell_st_t;

endpackage

[hdl/ffhp_div.sv]
module ffhp_div import ffhp_pkg::*; #(
	parameter int unsigned FRAC_BITS = 30
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          dividend,
	input  logic [31:0]          divisor,
	output logic                 done,
	output logic [FRAC_BITS:0]   quotient
);

	localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAC_BITS - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [31:0]          rem_q;
	logic [31:0]          div_q;
	logic [FRAC_BITS:0]   quo_q;

	logic [32:0] rem_x2;
	logic        ge;
	logic [32:0] rem_sub;

	// Dividend never exceeds divisor: the integer bit is set only on equality
	always_comb begin
		rem_x2  = {rem_q, 1'b0};
		ge      = rem_x2 >= {1'b0, div_q};
		rem_sub = rem_x2 - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			if (dividend == divisor) begin
				rem_q <= '0;
				quo_q <= (FRAC_BITS+1)'(1);
			end else begin
				rem_q <= dividend;
				quo_q <= '0;
			end
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[31:0] : rem_x2[31:0];
			quo_q <= {quo_q[FRAC_BITS-1:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hdl/ffhp_cell.sv]
module ffhp_cell import ffhp_pkg::*; #(
	parameter int unsigned FRAC_BITS = 30,
	parameter bit          FIRST     = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffhp_cmd_t           cmd,
	input  logic [PROD_W-1:0]   factor,
	input  ffhp_link_t          link_in,
	output ffhp_link_t          link_out,
	output ffhp_cell_st_t       st
);

	localparam logic [PROD_W-1:0]   ONE_FX = PROD_W'(64'd1 << FRAC_BITS);
	localparam logic [2*PROD_W-1:0] TWO_SQ = 64'd2 << (2 * FRAC_BITS);

	logic                open_q;
	logic [PROD_W-1:0]   prod_q;
	logic [2*PROD_W-1:0] prod_s1;
	logic                fit;

	always_ff @(posedge clk) begin
		prod_s1 <= (2*PROD_W)'(prod_q) * (2*PROD_W)'(factor);
	end

	always_comb begin
		fit               = open_q && (prod_s1 <= TWO_SQ);
		st.take           = fit && !link_in.claimed;
		st.open_new       = !open_q && link_in.open && !link_in.claimed;
		link_out.claimed  = link_in.claimed || fit;
		link_out.open     = open_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= FIRST;
			prod_q <= ONE_FX;
		end else if (cmd.clear) begin
			open_q <= FIRST;
			prod_q <= ONE_FX;
		end else if (cmd.commit) begin
			if (st.take) begin
				prod_q <= prod_s1[FRAC_BITS +: PROD_W];
			end else if (st.open_new) begin
				open_q <= 1'b1;
				prod_q <= factor;
			end
		end
	end

endmodule

[hdl/first_fit_hyperbolic_task_partitioner.sv]
// Channel  Direction  Handshake          Carries
// in       request    in_valid/in_stall  new_set, period, exec_time
// out      result     out_valid/out_stall assigned_processor, processors_used,
//                                        within_limit, error_code
// cfg      write      cfg_valid/cfg_ready processor_limit
//
// A placed task passes from acceptance to a result through the shared divider,
// which makes one quotient bit of the utilization per cycle, then the
// per-processor multiply, then the decision. A task with a zero period or with
// utilization above one skips the divider and reports an error.
// Reset opens processor 0 and sets every product to 1.0; no clearing pass.
// A waiting result stalls the decision, and with it the acceptance of the next request.
module first_fit_hyperbolic_task_partitioner import ffhp_pkg::*; #(
	parameter int unsigned MAX_PROCS = 16,
	parameter int unsigned FRAC_BITS = 30
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  ffhp_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output ffhp_out_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [4:0] cfg_data
);

	localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
	localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;
	localparam logic [PROD_W-1:0] ONE_FX = PROD_W'(64'd1 << FRAC_BITS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_PICK,
		S_BAD
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [4:0]         lim_q;
	logic [PROD_W-1:0]  factor_q;
	logic               out_valid_q;
	ffhp_out_t          out_q;

	logic               accept;
	logic               bad;
	logic               out_free;
	logic               out_load;
	logic               div_done;
	logic [FRAC_BITS:0] quo;
	ffhp_cmd_t          cmd;

	ffhp_link_t         link [0:MAX_PROCS];
	ffhp_cell_st_t      cst  [0:MAX_PROCS-1];

	logic               placed;
	logic               opened;
	logic [IDX_W-1:0]   idx;
	logic [CNT_W-1:0]   cnt_next;
	logic [CNT_W-1:0]   cnt_rep;
	logic [CMP_W-1:0]   cnt_cmp;
	logic [CMP_W-1:0]   lim_cmp;
	logic [IDX_W+3:0]   idx_ext;
	logic [CNT_W+4:0]   cnt_ext;
	ffhp_err_t          err;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign bad       = (in_data.period == 32'd0) || (in_data.exec_time > in_data.period);
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// Load the result register when a decision or an error report is ready
	assign out_load  = out_free && (state_q == S_PICK || state_q == S_BAD);

	// Clear the cells together with the request that opens a new set
	assign cmd.clear  = accept && in_data.new_set;
	assign cmd.commit = (state_q == S_PICK) && out_free;

	ffhp_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && !bad),
		.dividend (in_data.exec_time),
		.divisor  (in_data.period),
		.done     (div_done),
		.quotient (quo)
	);

	// The chain: a claim ripples from processor 0 upward, and the first closed
	// processor behind an unclaimed chain opens for the task
	assign link[0] = '{claimed: 1'b0, open: 1'b1};

	for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
		ffhp_cell #(
			.FRAC_BITS (FRAC_BITS),
			.FIRST     (g == 0)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.factor   (factor_q),
			.link_in  (link[g]),
			.link_out (link[g+1]),
			.st       (cst[g])
		);
	end

	// At most one cell takes or opens, so OR the indices together
	always_comb begin
		placed = 1'b0;
		opened = 1'b0;
		idx    = '0;
		for (int i = 0; i < MAX_PROCS; i++) begin
			placed = placed | cst[i].take;
			opened = opened | cst[i].open_new;
			if (cst[i].take || cst[i].open_new) begin
				idx = idx | IDX_W'(i);
			end
		end
	end

	always_comb begin
		cnt_next = cnt_q + CNT_W'(opened);
		cnt_rep  = (state_q == S_PICK) ? cnt_next : cnt_q;
		cnt_cmp  = CMP_W'(cnt_rep);
		lim_cmp  = CMP_W'(lim_q);
		idx_ext  = {4'b0, idx};
		cnt_ext  = {5'b0, cnt_rep};
		if (state_q == S_BAD) begin
			err = ERR_UTIL_OVER;
		end else if (!placed && !opened) begin
			err = ERR_NO_PROC;
		end else begin
			err = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			lim_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_data.new_set) begin
							cnt_q <= CNT_W'(1);
						end
						state_q <= bad ? S_BAD : S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (out_free) begin
						cnt_q   <= cnt_next;
						state_q <= S_IDLE;
					end
				end
				S_BAD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the factor from the end of the division until the decision
	always_ff @(posedge clk) begin
		if (div_done) begin
			factor_q <= ONE_FX + PROD_W'(quo);
		end
		if (out_load) begin
			out_q.assigned_processor <= (err == ERR_NONE) ? idx_ext[3:0] : 4'd0;
			out_q.processors_used    <= cnt_ext[4:0];
			out_q.within_limit       <= (lim_q == 5'd0) || (cnt_cmp <= lim_cmp);
			out_q.error_code         <= err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
